// ----- hdl/bfmv_pkg.sv -----
// Shared types and constants for the bfloat16 matrix-vector product block.
`timescale 1ns / 1ps
package bfmv_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int BF16_W       = 16;
   localparam int ROWS_W       = 16;
   localparam int COLS_CFG_W   = 11;
   localparam int INDEX_W      = 17;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_OFFSET = 2'd2;

   localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
   localparam logic [31:0] F32_INF   = 32'h7F80_0000;
   localparam logic [15:0] BF16_QNAN = 16'h7FC0;

   // Per-element tag that rides along the arithmetic pipeline.
   typedef struct packed {
      logic                end_row;
      logic                last_row;
      logic [INDEX_W-1:0]  index;
   } row_tag_type;

endpackage

// ----- hdl/bfmv_if.sv -----
// Handshake channel interfaces: input items, results and register writes.
`timescale 1ns / 1ps
interface bfmv_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [bfmv_pkg::BF16_W-1:0]  value;
   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bfmv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfmv_pkg::BF16_W-1:0]   result_value;
   logic [bfmv_pkg::INDEX_W-1:0]  result_index;
   logic                          last_row;
   modport source (output valid, output result_value, output result_index,
                   output last_row, input ready);
   modport sink   (input valid, input result_value, input result_index,
                   input last_row, output ready);
endinterface

interface bfmv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bfmv_pkg::CSR_IDX_W-1:0]  index;
   logic [bfmv_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/bfmv_vec_mem.sv -----
// Vector element store: one write port, one registered read port.
`timescale 1ns / 1ps
module bfmv_vec_mem #(
   parameter int DEPTH = bfmv_pkg::MAX_COLS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bfmv_pkg::BF16_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bfmv_pkg::BF16_W-1:0] rd_data
);

   logic [bfmv_pkg::BF16_W-1:0] mem [DEPTH];
   logic [bfmv_pkg::BF16_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bfmv_mul.sv -----
// Exact bfloat16 product, then rounding of the product to binary32; two stages.
`timescale 1ns / 1ps
module bfmv_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  bfmv_pkg::row_tag_type       in_tag,
   input  logic [bfmv_pkg::BF16_W-1:0] a_value,
   input  logic [bfmv_pkg::BF16_W-1:0] b_value,
   output logic                        out_valid,
   output bfmv_pkg::row_tag_type       out_tag,
   output logic [31:0]                 out_prod
);

   // product stage
   logic                  p_valid_ff;
   bfmv_pkg::row_tag_type p_tag_ff;
   logic                  p_sign_ff, p_sign_in;
   logic                  p_nan_ff, p_nan_in;
   logic                  p_inf_ff, p_inf_in;
   logic                  p_zero_ff, p_zero_in;
   logic [8:0]            p_exp_ff, p_exp_in;
   logic [15:0]           p_mant_ff, p_mant_in;

   // rounded stage
   logic                  f_valid_ff;
   bfmv_pkg::row_tag_type f_tag_ff;
   logic [31:0]           f_prod_ff, f_prod_in;

   logic [7:0] ea, eb;
   logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   always_comb begin
      ea     = a_value[14:7];
      eb     = b_value[14:7];
      a_nan  = (&ea) && (|a_value[6:0]);
      b_nan  = (&eb) && (|b_value[6:0]);
      a_inf  = (&ea) && !(|a_value[6:0]);
      b_inf  = (&eb) && !(|b_value[6:0]);
      a_zero = !(|a_value[14:0]);
      b_zero = !(|b_value[14:0]);
      p_sign_in = a_value[15] ^ b_value[15];
      p_nan_in  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      p_inf_in  = a_inf || b_inf;
      p_zero_in = a_zero || b_zero;
      p_exp_in  = {1'b0, (ea == 8'd0) ? 8'd1 : ea} + {1'b0, (eb == 8'd0) ? 8'd1 : eb};
      p_mant_in = {|ea, a_value[6:0]} * {|eb, b_value[6:0]};
   end

   // Value is mant * 2^(exp - 268); normalise and pack, shifting right with
   // nearest-even rounding when the product lands below the normal range.
   logic [4:0]         lz;
   logic [15:0]        norm;
   logic signed [10:0] be;
   logic [10:0]        neg_be;
   logic [4:0]         sh;
   logic [47:0]        wide;
   logic               up;
   logic [23:0]        frac;

   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (p_mant_ff[i]) begin
            lz = 5'(15 - i);
         end
      end
      norm   = p_mant_ff << lz;
      be     = $signed({2'b00, p_exp_ff}) - 11'sd126 - $signed({6'b0, lz});
      neg_be = 11'(-be);
      sh     = (be < 0 && neg_be > 11'd25) ? 5'd25 : (be < 0 ? neg_be[4:0] : 5'd0);
      wide   = {norm, 7'b0, 25'b0} >> sh;
      up     = wide[24] && ((|wide[23:0]) || wide[25]);
      frac   = {1'b0, wide[47:25]} + {23'b0, up};
      if (p_nan_ff) begin
         f_prod_in = bfmv_pkg::F32_QNAN;
      end else if (p_inf_ff) begin
         f_prod_in = {p_sign_ff, bfmv_pkg::F32_INF[30:0]};
      end else if (p_zero_ff) begin
         f_prod_in = {p_sign_ff, 31'b0};
      end else if (be >= 11'sd255) begin
         f_prod_in = {p_sign_ff, bfmv_pkg::F32_INF[30:0]};
      end else if (be >= 11'sd1) begin
         f_prod_in = {p_sign_ff, be[7:0], norm[14:0], 8'b0};
      end else begin
         f_prod_in = {p_sign_ff, 7'b0, frac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= in_valid;
         f_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_tag_ff  <= in_tag;
         p_sign_ff <= p_sign_in;
         p_nan_ff  <= p_nan_in;
         p_inf_ff  <= p_inf_in;
         p_zero_ff <= p_zero_in;
         p_exp_ff  <= p_exp_in;
         p_mant_ff <= p_mant_in;
         f_tag_ff  <= p_tag_ff;
         f_prod_ff <= f_prod_in;
      end
   end

   assign out_valid = f_valid_ff;
   assign out_tag   = f_tag_ff;
   assign out_prod  = f_prod_ff;

endmodule

// ----- hdl/bfmv_acc.sv -----
// Binary32 accumulator with round-to-nearest-even add and the result register.
`timescale 1ns / 1ps
module bfmv_acc (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  bfmv_pkg::row_tag_type        in_tag,
   input  logic [31:0]                  in_prod,
   output logic                         hold,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bfmv_pkg::BF16_W-1:0]  rsp_value,
   output logic [bfmv_pkg::INDEX_W-1:0] rsp_index,
   output logic                         rsp_last
);

   function automatic logic [31:0] f32_add(input logic [31:0] x, input logic [31:0] y);
      logic        x_nan, y_nan, x_inf, y_inf, swap, eff_sub, sticky, up;
      logic [31:0] big, sml, res;
      logic [8:0]  el, es, d;
      logic [4:0]  sh, lz;
      logic [26:0] ml, ms, al, nrm;
      logic [53:0] shw;
      logic [27:0] sum;
      logic [9:0]  e;
      logic [24:0] r;
      begin
         x_nan = (&x[30:23]) && (|x[22:0]);
         y_nan = (&y[30:23]) && (|y[22:0]);
         x_inf = (&x[30:23]) && !(|x[22:0]);
         y_inf = (&y[30:23]) && !(|y[22:0]);
         swap  = y[30:0] > x[30:0];
         big   = swap ? y : x;
         sml   = swap ? x : y;
         el    = {1'b0, (big[30:23] == 8'd0) ? 8'd1 : big[30:23]};
         es    = {1'b0, (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23]};
         ml    = {|big[30:23], big[22:0], 3'b0};
         ms    = {|sml[30:23], sml[22:0], 3'b0};
         d     = el - es;
         sh    = (d > 9'd28) ? 5'd28 : d[4:0];
         shw   = {ms, 27'b0} >> sh;
         sticky = |shw[26:0];
         al    = shw[53:27] | {26'b0, sticky};
         eff_sub = big[31] ^ sml[31];
         sum   = eff_sub ? ({1'b0, ml} - {1'b0, al}) : ({1'b0, ml} + {1'b0, al});
         e     = {1'b0, el};
         if (sum[27]) begin
            nrm = sum[27:1] | {26'b0, sum[0]};
            e   = e + 10'd1;
         end else begin
            nrm = sum[26:0];
         end
         lz = 5'd0;
         for (int i = 0; i < 27; i++) begin
            if (nrm[i]) begin
               lz = 5'(26 - i);
            end
         end
         if ({5'b0, lz} >= e) begin
            lz = 5'(e - 10'd1);
         end
         nrm = nrm << lz;
         e   = e - {5'b0, lz};
         up  = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
         r   = {1'b0, nrm[26:3]} + {24'b0, up};
         // Exponent field plus the full significand: a carry out of the
         // significand bumps the exponent, subnormals come out with e of one.
         res = ({22'b0, e - 10'd1} << 23) + {7'b0, r};
         if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
            f32_add = bfmv_pkg::F32_QNAN;
         end else if (x_inf) begin
            f32_add = x;
         end else if (y_inf) begin
            f32_add = y;
         end else if (sum == 28'd0) begin
            f32_add = {big[31] & sml[31], 31'b0};
         end else if (res[30:0] >= bfmv_pkg::F32_INF[30:0]) begin
            f32_add = {big[31], bfmv_pkg::F32_INF[30:0]};
         end else begin
            f32_add = {big[31], res[30:0]};
         end
      end
   endfunction

   function automatic logic [15:0] f32_to_bf16(input logic [31:0] w);
      logic [31:0] t;
      begin
         t = w + 32'h0000_7FFF + {31'b0, w[16]};
         if ((&w[30:23]) && (|w[22:0])) begin
            f32_to_bf16 = bfmv_pkg::BF16_QNAN;
         end else begin
            f32_to_bf16 = t[31:16];
         end
      end
   endfunction

   logic [31:0]                  acc_ff, acc_in;
   logic [31:0]                  sum;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bfmv_pkg::BF16_W-1:0]  rsp_value_ff;
   logic [bfmv_pkg::INDEX_W-1:0] rsp_index_ff;
   logic                         rsp_last_ff;
   logic                         take, emit;

   assign sum  = f32_add(acc_ff, in_prod);
   assign take = adv && in_valid;
   assign emit = take && in_tag.end_row;
   assign hold = in_valid && in_tag.end_row && rsp_valid_ff && !rsp_ready;

   always_comb begin
      acc_in = acc_ff;
      if (take) begin
         acc_in = in_tag.end_row ? 32'd0 : sum;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= f32_to_bf16(sum);
         rsp_index_ff <= in_tag.index;
         rsp_last_ff  <= in_tag.last_row;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- hdl/bf16_matrix_vector_product.sv -----
// Top level of the bfloat16 matrix-vector product with binary32 accumulation.
`timescale 1ns / 1ps
// Usage:
//  - req carries one beat per element: kind 0 loads the next vector element,
//    kind 1 streams the next matrix element in row-major order.
//  - csr writes num_rows, num_cols and output_offset by index; write them only
//    while no beat is in flight. csr.ready is always high.
//  - rsp gives one beat per finished row: the row's sum rounded to bfloat16,
//    its index (output_offset plus row number) and a flag on the final row.
//  - A row's result reaches rsp once its last matrix beat is taken and has
//    passed the vector read alongside the beat, then product, binary32
//    rounding and accumulate.
//  - Throughput: one beat per cycle on req while the pipeline is not stalled;
//    the accumulator add is combinational into its register, which sets the rate.
//  - While a result waits on rsp, req keeps taking beats; only a second row
//    end arriving at the accumulator stalls the pipeline and drops req.ready.
//  - Reset clears counters, accumulator (+0) and valid bits and restores the
//    registers to one row, one column, offset zero. The vector store keeps
//    no reset value: load it before streaming the matrix.
module bf16_matrix_vector_product #(
   parameter int MAX_COLS = bfmv_pkg::MAX_COLS_DEF
) (
   input logic          clock,
   input logic          reset,
   bfmv_req_if.sink     req,
   bfmv_rsp_if.source   rsp,
   bfmv_csr_if.sink     csr
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CW = AW + 1;

   // configuration registers
   logic [bfmv_pkg::ROWS_W-1:0]     num_rows_ff;
   logic [bfmv_pkg::COLS_CFG_W-1:0] num_cols_ff;
   logic [bfmv_pkg::ROWS_W-1:0]     offset_ff;

   // position counters
   logic [AW-1:0]               vlc_ff, vlc_in;
   logic [AW-1:0]               col_ff, col_in;
   logic [bfmv_pkg::ROWS_W-1:0] row_ff, row_in;

   logic [CW-1:0]               cols;
   logic [bfmv_pkg::ROWS_W-1:0] rows;
   logic [CW-1:0]               vlc_next, col_next;
   logic [bfmv_pkg::ROWS_W:0]   row_next;

   logic                        adv, hold, accept, load, stream;
   bfmv_pkg::row_tag_type       tag_in;

   // first pipeline stage: matrix element and its tag, vector element read
   logic                        s1_valid_ff;
   bfmv_pkg::row_tag_type       s1_tag_ff;
   logic [bfmv_pkg::BF16_W-1:0] s1_value_ff;
   logic [bfmv_pkg::BF16_W-1:0] vec_value;

   logic                        m_valid;
   bfmv_pkg::row_tag_type       m_tag;
   logic [31:0]                 m_prod;

   assign adv       = !hold;
   assign req.ready = adv;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && adv;
   assign load      = accept && !req.kind;
   assign stream    = accept && req.kind;

   // Column count in use: zero acts as one, anything over the store depth
   // is clipped to it.
   always_comb begin
      if (num_cols_ff == '0) begin
         cols = CW'(1);
      end else if (32'(num_cols_ff) > 32'(MAX_COLS)) begin
         cols = CW'(MAX_COLS);
      end else begin
         cols = CW'(num_cols_ff);
      end
      rows = (num_rows_ff == '0) ? bfmv_pkg::ROWS_W'(1) : num_rows_ff;
   end

   always_comb begin
      vlc_next = {1'b0, vlc_ff} + CW'(1);
      col_next = {1'b0, col_ff} + CW'(1);
      row_next = {1'b0, row_ff} + 17'd1;

      tag_in.end_row  = col_next >= cols;
      tag_in.last_row = row_next >= {1'b0, rows};
      tag_in.index    = {1'b0, offset_ff} + {1'b0, row_ff};

      vlc_in = vlc_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (load) begin
         vlc_in = (vlc_next >= cols) ? '0 : vlc_next[AW-1:0];
      end
      if (stream) begin
         if (tag_in.end_row) begin
            col_in = '0;
            row_in = tag_in.last_row ? '0 : row_next[bfmv_pkg::ROWS_W-1:0];
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= bfmv_pkg::ROWS_W'(1);
         num_cols_ff <= bfmv_pkg::COLS_CFG_W'(1);
         offset_ff   <= '0;
         vlc_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               bfmv_pkg::CSR_NUM_ROWS:      num_rows_ff <= csr.data;
               bfmv_pkg::CSR_NUM_COLS:      num_cols_ff <= csr.data[bfmv_pkg::COLS_CFG_W-1:0];
               bfmv_pkg::CSR_OUTPUT_OFFSET: offset_ff   <= csr.data;
               default: ;
            endcase
         end
         vlc_ff <= vlc_in;
         col_ff <= col_in;
         row_ff <= row_in;
         if (adv) begin
            s1_valid_ff <= stream;
         end
      end
   end

   // Hold the payload while stalled so it lines up with the held vector read.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff   <= tag_in;
         s1_value_ff <= req.value;
      end
   end

   bfmv_vec_mem #(
      .DEPTH (MAX_COLS),
      .AW    (AW)
   ) u_vec_mem (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (vlc_ff),
      .wr_data (req.value),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (vec_value)
   );

   bfmv_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s1_valid_ff),
      .in_tag    (s1_tag_ff),
      .a_value   (s1_value_ff),
      .b_value   (vec_value),
      .out_valid (m_valid),
      .out_tag   (m_tag),
      .out_prod  (m_prod)
   );

   bfmv_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m_valid),
      .in_tag    (m_tag),
      .in_prod   (m_prod),
      .hold      (hold),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_value (rsp.result_value),
      .rsp_index (rsp.result_index),
      .rsp_last  (rsp.last_row)
   );

endmodule

// ----- bench/bf16_matrix_vector_product_tb.sv -----
// Self-checking testbench for the bfloat16 matrix-vector product block.
`timescale 1ns / 1ps
module bf16_matrix_vector_product_tb;

   localparam int  NUM_COLS_MAX = bfmv_pkg::MAX_COLS_DEF;
   localparam bit  KIND_VECTOR  = 1'b0;
   localparam bit  KIND_MATRIX  = 1'b1;
   localparam int  NUM_PHASES   = 6;
   localparam int  SETTLE_CYCLES = 8;   // pipeline depth plus margin

   typedef struct {
      bit                          kind;
      bit [bfmv_pkg::BF16_W-1:0]   value;
      bit                          known;      // result value can be read off directly
      bit [bfmv_pkg::BF16_W-1:0]   want;
   } stim_row_type;

   typedef struct {
      bit [bfmv_pkg::BF16_W-1:0]   value;
      bit [bfmv_pkg::INDEX_W-1:0]  index;
      bit                          last;
   } row_result_type;

   typedef struct {
      bit [15:0] rows;
      bit [15:0] cols;
      bit [15:0] offset;
      int        items;
   } phase_type;

   logic clock;
   logic reset;

   bfmv_req_if req ();
   bfmv_rsp_if rsp ();
   bfmv_csr_if csr ();

   bf16_matrix_vector_product dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // Clock: 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Predictor state: our own copy of the vector, counters and registers.
   // ------------------------------------------------------------------
   bit [bfmv_pkg::BF16_W-1:0] vec_mem [NUM_COLS_MAX];
   bit              vec_written [NUM_COLS_MAX];
   int unsigned     vec_fill;
   bit [31:0]       acc_f32;
   int unsigned     col_pos;
   int unsigned     row_pos;
   bit [15:0]       reg_rows;
   bit [10:0]       reg_cols;
   bit [15:0]       reg_offset;

   row_result_type  pending_rows[$];

   int              fail_count;
   int              rows_checked;
   int              beats_sent;
   int              vector_beats;
   int              matrix_beats;

   // Idle percentages for the two sides; changed as the run advances.
   int              req_gap_pct;
   int              rsp_stall_pct;

   // Widen a binary32 pattern to a real, exactly.
   function automatic real f32_to_real(bit [31:0] w);
      bit [63:0] d;
      int        e;
      bit [22:0] f;
      d[63] = w[31];
      f     = w[22:0];
      if (w[30:23] == 8'hFF) begin
         d[62:52] = 11'h7FF;
         d[51:0]  = {f, 29'd0};
      end else if (w[30:23] == 8'd0) begin
         if (f == 23'd0) begin
            d[62:0] = '0;
         end else begin
            // normalise the subnormal
            e = -126;
            while (f[22] == 1'b0) begin
               f = f << 1;
               e = e - 1;
            end
            f = f << 1;
            e = e - 1;
            d[62:52] = 11'(e + 1023);
            d[51:0]  = {f, 29'd0};
         end
      end else begin
         d[62:52] = 11'(int'(w[30:23]) - 127 + 1023);
         d[51:0]  = {f, 29'd0};
      end
      return $bitstoreal(d);
   endfunction

   // Round a real to binary32, nearest even, with subnormals and overflow.
   function automatic bit [31:0] real_to_f32(real r);
      bit [63:0] d;
      bit [63:0] sig;
      bit [63:0] kept;
      bit [63:0] rem;
      bit [63:0] half;
      int        e;
      int        fe;
      int        shift;
      d = $realtobits(r);
      if (d[62:52] == 11'h7FF) begin
         if (d[51:0] != 0) return 32'h7FC0_0000;
         return {d[63], 31'h7F80_0000};
      end
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      e   = int'(d[62:52]) - 1023;
      sig = {11'd0, 1'b1, d[51:0]};
      shift = (e >= -126) ? 29 : 29 + (-126 - e);
      if (shift > 60) return {d[63], 31'd0};
      kept = sig >> shift;
      half = 64'd1 << (shift - 1);
      rem  = sig & ((64'd1 << shift) - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      if (e < -126) return {d[63], kept[30:0]};   // subnormal, may carry to normal
      fe = e + 127;
      if (kept[24]) begin
         kept = kept >> 1;
         fe   = fe + 1;
      end
      if (fe >= 255) return {d[63], 31'h7F80_0000};
      return {d[63], fe[7:0], kept[22:0]};
   endfunction

   function automatic bit [15:0] f32_round_bf16(bit [31:0] w);
      bit [31:0] t;
      if (w[30:23] == 8'hFF && w[22:0] != 0) return bfmv_pkg::BF16_QNAN;
      t = w + 32'h7FFF + {31'd0, w[16]};
      return t[31:16];
   endfunction

   function automatic int unsigned cols_active();
      if (reg_cols == 0) return 1;
      if (reg_cols > NUM_COLS_MAX) return NUM_COLS_MAX;
      return reg_cols;
   endfunction

   // Advance the dot-product state by one accepted beat; returns 1 with the
   // row result when this beat closes a row.
   function automatic bit dot_product_step(bit kind, bit [15:0] value,
                                           output row_result_type res);
      int unsigned cols;
      int unsigned rows;
      int unsigned slot;
      bit [31:0]   prod;
      bit          last;
      cols = cols_active();
      rows = (reg_rows == 0) ? 1 : reg_rows;
      res  = '{default: 0};
      if (kind == KIND_VECTOR) begin
         slot = vec_fill % NUM_COLS_MAX;
         vec_mem[slot]     = value;
         vec_written[slot] = 1'b1;
         vec_fill++;
         if (vec_fill >= cols) vec_fill = 0;
         return 1'b0;
      end
      slot = col_pos % NUM_COLS_MAX;
      prod = real_to_f32(f32_to_real({value, 16'd0})
                         * f32_to_real({vec_mem[slot], 16'd0}));
      // binary64 add then one rounding equals a binary32 add
      acc_f32 = real_to_f32(f32_to_real(acc_f32) + f32_to_real(prod));
      col_pos++;
      if (col_pos < cols) return 1'b0;
      last       = (row_pos + 1) >= rows;
      res.value  = f32_round_bf16(acc_f32);
      res.index  = 17'(reg_offset + row_pos);
      res.last   = last;
      acc_f32    = 32'd0;
      col_pos    = 0;
      row_pos    = last ? 0 : ((row_pos + 1) & 16'hFFFF);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Drivers. valid is left high between back-to-back beats and only
   // dropped when a gap starts, so no signal gets two updates per step.
   // ------------------------------------------------------------------
   task automatic send_beat(bit kind, bit [15:0] value, output row_result_type res,
                            output bit has_res);
      while ($urandom_range(99) < req_gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind  <= kind;
      req.value <= value;
      do @(posedge clock); while (!req.ready);
      has_res = dot_product_step(kind, value, res);
      if (has_res) pending_rows.push_back(res);
      beats_sent++;
      if (kind == KIND_VECTOR) vector_beats++;
      else matrix_beats++;
   endtask

   task automatic write_reg(bit [bfmv_pkg::CSR_IDX_W-1:0] idx, bit [15:0] data);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      case (idx)
         bfmv_pkg::CSR_NUM_ROWS:      reg_rows   = data;
         bfmv_pkg::CSR_NUM_COLS:      reg_cols   = data[10:0];
         bfmv_pkg::CSR_OUTPUT_OFFSET: reg_offset = data;
         default: ;
      endcase
   endtask

   // Drop req, let every expected row drain, then let the pipe settle so a
   // half-finished row cannot be hit by the register write.
   task automatic drain_pipeline();
      req.valid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly moderate exponents so sums cancel and round; some raw patterns
   // and specials so every bit and every class turns up.
   function automatic bit [15:0] random_bf16();
      bit [15:0] specials [8] = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80,
                                 16'h7FC0, 16'h0001, 16'h7F7F, 16'h0080};
      int        pick;
      pick = $urandom_range(99);
      if (pick < 6) return specials[$urandom_range(7)];
      if (pick < 18) return 16'($urandom);
      return {1'($urandom), 8'($urandom_range(8'h8C, 8'h72)), 7'($urandom)};
   endfunction

   // ------------------------------------------------------------------
   // Result side: random back-pressure, check every beat in order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      row_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_rows.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected row beat: value %h index %0d last %0b",
                           rsp.result_value, rsp.result_index, rsp.last_row);
            end else begin
               want = pending_rows.pop_front();
               rows_checked++;
               if (rsp.result_value !== want.value || rsp.result_index !== want.index
                   || rsp.last_row !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("row mismatch: want %h/%0d/%0b got %h/%0d/%0b",
                              want.value, want.index, want.last, rsp.result_value,
                              rsp.result_index, rsp.last_row);
               end
            end
         end
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("bf16_matrix_vector_product: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   stim_row_type directed_rows[20];
   phase_type    phases[NUM_PHASES];

   initial begin
      row_result_type res;
      bit          has_res;
      bit          kind;
      int          total_random;
      int          random_done;

      req.valid = 1'b0;
      req.kind  = 1'b0;
      req.value = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data  = '0;
      reset     = 1'b1;
      fail_count = 0;
      rows_checked = 0;
      beats_sent = 0;
      vector_beats = 0;
      matrix_beats = 0;
      req_gap_pct = 28;
      rsp_stall_pct = 66;

      // After reset: one row, one column, offset zero.
      foreach (vec_mem[i]) begin
         vec_mem[i]     = '0;
         vec_written[i] = 1'b0;
      end
      vec_fill   = 0;
      acc_f32    = 32'd0;
      col_pos    = 0;
      row_pos    = 0;
      reg_rows   = 16'd1;
      reg_cols   = 11'd1;
      reg_offset = 16'd0;

      // Single-column dot products: each matrix beat is one finished row.
      directed_rows = '{
         '{KIND_VECTOR, 16'h3F80, 0, 16'h0000},   // vector = 1.0
         '{KIND_MATRIX, 16'h3F80, 1, 16'h3F80},
         '{KIND_MATRIX, 16'h0000, 1, 16'h0000},
         '{KIND_MATRIX, 16'h8000, 1, 16'h0000},   // +0 plus -0 stays +0
         '{KIND_MATRIX, 16'h7F80, 1, 16'h7F80},
         '{KIND_MATRIX, 16'hFF80, 1, 16'hFF80},
         '{KIND_MATRIX, 16'h7FC1, 1, 16'h7FC0},   // any NaN leaves as quiet NaN
         '{KIND_VECTOR, 16'h0000, 0, 16'h0000},
         '{KIND_MATRIX, 16'h7F80, 1, 16'h7FC0},   // infinity times zero
         '{KIND_VECTOR, 16'h7F7F, 0, 16'h0000},
         '{KIND_MATRIX, 16'h7F7F, 1, 16'h7F80},   // product overflows
         '{KIND_VECTOR, 16'h0001, 0, 16'h0000},
         '{KIND_MATRIX, 16'h0001, 1, 16'h0000},   // product underflows
         '{KIND_VECTOR, 16'hFFFF, 0, 16'h0000},
         '{KIND_MATRIX, 16'h3F80, 1, 16'h7FC0},
         '{KIND_VECTOR, 16'h3F80, 0, 16'h0000},
         '{KIND_MATRIX, 16'hFFFF, 1, 16'h7FC0},
         '{KIND_MATRIX, 16'h0080, 1, 16'h0080},   // smallest normal
         '{KIND_VECTOR, 16'hC000, 0, 16'h0000},
         '{KIND_MATRIX, 16'h4040, 1, 16'hC0C0}    // -2 * 3
      };

      // rows, cols, offset, random beats. Zero counts act as one, a column
      // count above the store acts as its size; offset plus row carries into a 17th index bit.
      phases = '{
         '{16'd5,     16'd3,    16'd100,   150},
         '{16'd0,     16'd0,    16'd65535, 80},
         '{16'd65535, 16'd2,    16'd65535, 150},
         '{16'd2,     16'd2047, 16'd7,     200},
         '{16'd7,     16'd4,    16'd1,     120},
         '{16'd65535, 16'd1,    16'd0,     80}
      };
      total_random = 0;
      foreach (phases[p]) total_random += phases[p].items;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].kind, directed_rows[i].value, res, has_res);
         if (directed_rows[i].known && (!has_res || res.value != directed_rows[i].want)) begin
            fail_count++;
            if (fail_count <= 10)
               $display("directed row %0d: predicted %h, table says %h",
                        i, res.value, directed_rows[i].want);
         end
      end

      random_done = 0;
      foreach (phases[p]) begin
         drain_pipeline();
         write_reg(bfmv_pkg::CSR_NUM_ROWS, phases[p].rows);
         write_reg(bfmv_pkg::CSR_NUM_COLS, phases[p].cols);
         write_reg(bfmv_pkg::CSR_OUTPUT_OFFSET, phases[p].offset);
         csr.valid <= 1'b0;
         for (int n = 0; n < phases[p].items; n++) begin
            // swap the idling roles after a third, stop idling after two
            if (random_done == total_random / 3) begin
               req_gap_pct   = 66;
               rsp_stall_pct = 28;
            end else if (random_done == 2 * total_random / 3) begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            // never stream a column whose vector element was never loaded
            if (!vec_written[col_pos % NUM_COLS_MAX]) kind = KIND_VECTOR;
            else kind = ($urandom_range(99) < 80) ? KIND_MATRIX : KIND_VECTOR;
            send_beat(kind, random_bf16(), res, has_res);
            random_done++;
         end
      end

      drain_pipeline();

      $display("covered %0d beats (%0d vector, %0d matrix), %0d rows checked",
               beats_sent, vector_beats, matrix_beats, rows_checked);
      $display("register settings swept: %0d, mismatches: %0d", NUM_PHASES + 1, fail_count);
      if (fail_count == 0) begin
         $display("bf16_matrix_vector_product: match");
      end else begin
         $display("bf16_matrix_vector_product: mismatch");
      end
      $finish;
   end

endmodule
